### design/tvmp_pkg.sv
// Package for the mode-n tensor-times-vector product block.
// Holds register codes, fixed field widths and the structs passed between modules.
`timescale 1ns / 1ps

package tvmp_pkg;

  localparam int ADDR_WIDTH  = 4;
  localparam int LEFT_W      = 17;
  localparam int VLEN_W      = 11;
  localparam int RIGHT_W     = 13;
  localparam int LEFT_CNT_W  = 16;
  localparam int POS_WIDTH   = 28;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEFT_W-1:0] LEFT_MAX = 17'd65536;

  typedef enum logic [1:0] {
    REG_LEFT_COUNT    = 2'd0,
    REG_VECTOR_LENGTH = 2'd1,
    REG_RIGHT_COUNT   = 2'd2
  } tvmp_reg_e;

  typedef struct packed {
    logic [LEFT_W-1:0]  left_count;
    logic [VLEN_W-1:0]  vector_length;
    logic [RIGHT_W-1:0] right_count;
  } tvmp_cfg_t;

  typedef struct packed {
    logic                 first;
    logic                 emit;
    logic                 last;
    logic [POS_WIDTH-1:0] pos;
  } tvmp_ctl_t;

endpackage

### design/tensor_vector_mode_product_top.sv
// Mode-n tensor-times-vector product: top level joining registers, front, queue and back.
// Throughput is one request per cycle while in_stall_o is low; the back part does one
// accumulator read-modify-write per cycle unless held by a stalled result, with the previous
// row's sum forwarded. A tensor element's result passes the front stage, queue entry, back
// stage, then the result register. Reset sets the registers to 1 and all counters to zero;
// the vector store and accumulators are not cleared, so no clearing pass is needed.
`timescale 1ns / 1ps

module tensor_vector_mode_product_top
  import tvmp_pkg::*;
#(
  parameter int VECTOR_DEPTH = 1024,
  parameter int ROW_DEPTH    = 4096,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic signed [31:0]    value_i,
  output logic                  result_valid_o,
  input  logic                  result_stall_i,
  output logic signed [63:0]    result_value_o,
  output logic [POS_WIDTH-1:0]  result_position_o,
  output logic                  last_result_o
);

  localparam int RA = $clog2(ROW_DEPTH);
  localparam int QW = 2 * VALUE_WIDTH + RA + $bits(tvmp_ctl_t);

  tvmp_cfg_t              cfg;
  logic                   cfg_clear;
  logic [QCOUNT_W-1:0]    q_count;
  logic                   push;
  logic [VALUE_WIDTH-1:0] push_value, push_vec, head_value, head_vec;
  logic [RA-1:0]          push_row, head_row;
  tvmp_ctl_t              push_ctl, head_ctl;
  logic                   head_valid, pop;
  logic [QW-1:0]          head_data;

  tvmp_regs #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .ROW_DEPTH    (ROW_DEPTH)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .cfg_clear_o (cfg_clear)
  );

  tvmp_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .ROW_DEPTH    (ROW_DEPTH),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cfg_clear_i  (cfg_clear),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .value_i      (value_i),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_value_o (push_value),
    .push_vec_o   (push_vec),
    .push_row_o   (push_row),
    .push_ctl_o   (push_ctl)
  );

  tvmp_fifo #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_value, push_vec, push_row, push_ctl}),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .data_o      (head_data),
    .count_o     (q_count)
  );

  assign {head_value, head_vec, head_row, head_ctl} = head_data;

  tvmp_back #(
    .ROW_DEPTH   (ROW_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .pop_o             (pop),
    .head_value_i      (head_value),
    .head_vec_i        (head_vec),
    .head_row_i        (head_row),
    .head_ctl_i        (head_ctl),
    .result_valid_o    (result_valid_o),
    .result_stall_i    (result_stall_i),
    .result_value_o    (result_value_o),
    .result_position_o (result_position_o),
    .last_result_o     (last_result_o)
  );

endmodule

### design/tvmp_regs.sv
// Configuration registers of the tensor-times-vector block behind an APB-style port.
// Depends on tvmp_pkg for register codes and the configuration struct.
`timescale 1ns / 1ps

module tvmp_regs
  import tvmp_pkg::*;
#(
  parameter int VECTOR_DEPTH = 1024,
  parameter int ROW_DEPTH    = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output tvmp_cfg_t             cfg_o,
  output logic                  cfg_clear_o
);

  tvmp_cfg_t          cfg_q, cfg_d;
  logic               wr_en;
  logic [LEFT_W-1:0]  left_v;
  logic [VLEN_W-1:0]  vlen_v;
  logic [RIGHT_W-1:0] right_v;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign left_v  = pwdata[LEFT_W-1:0];
  assign vlen_v  = pwdata[VLEN_W-1:0];
  assign right_v = pwdata[RIGHT_W-1:0];

  always_comb begin
    cfg_d       = cfg_q;
    cfg_clear_o = 1'b0;
    if (wr_en) begin
      unique case (tvmp_reg_e'(paddr[3:2]))
        REG_LEFT_COUNT: begin
          cfg_clear_o = 1'b1;
          if (left_v == '0) begin
            cfg_d.left_count = LEFT_W'(1);
          end else if (left_v > LEFT_MAX) begin
            cfg_d.left_count = LEFT_MAX;
          end else begin
            cfg_d.left_count = left_v;
          end
        end
        REG_VECTOR_LENGTH: begin
          cfg_clear_o = 1'b1;
          if (vlen_v == '0) begin
            cfg_d.vector_length = VLEN_W'(1);
          end else if (32'(vlen_v) > 32'(VECTOR_DEPTH)) begin
            cfg_d.vector_length = VLEN_W'(VECTOR_DEPTH);
          end else begin
            cfg_d.vector_length = vlen_v;
          end
        end
        REG_RIGHT_COUNT: begin
          cfg_clear_o = 1'b1;
          if (right_v == '0) begin
            cfg_d.right_count = RIGHT_W'(1);
          end else if (32'(right_v) > 32'(ROW_DEPTH)) begin
            cfg_d.right_count = RIGHT_W'(ROW_DEPTH);
          end else begin
            cfg_d.right_count = right_v;
          end
        end
        default: begin
          cfg_clear_o = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (tvmp_reg_e'(paddr[3:2]))
      REG_LEFT_COUNT:    prdata = 32'(cfg_q.left_count);
      REG_VECTOR_LENGTH: prdata = 32'(cfg_q.vector_length);
      REG_RIGHT_COUNT:   prdata = 32'(cfg_q.right_count);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_count    <= LEFT_W'(1);
      cfg_q.vector_length <= VLEN_W'(1);
      cfg_q.right_count   <= RIGHT_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/tvmp_fifo.sv
// Short request queue between the front and back parts of the block.
// Self-contained; holds packed requests in a small register array.
`timescale 1ns / 1ps

module tvmp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [W-1:0]                 push_data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output logic [W-1:0]                 data_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  assign data_o  = mem[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

### design/tvmp_front.sv
// Front part: accepts requests, loads the vector store and tracks the tensor indices.
// Depends on tvmp_pkg; feeds tvmp_fifo with classified stream requests.
`timescale 1ns / 1ps

module tvmp_front
  import tvmp_pkg::*;
#(
  parameter int VECTOR_DEPTH = 1024,
  parameter int ROW_DEPTH    = 4096,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tvmp_cfg_t                     cfg_i,
  input  logic                          cfg_clear_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic signed [31:0]            value_i,
  input  logic [QCOUNT_W-1:0]           q_count_i,
  output logic                          push_o,
  output logic [VALUE_WIDTH-1:0]        push_value_o,
  output logic [VALUE_WIDTH-1:0]        push_vec_o,
  output logic [$clog2(ROW_DEPTH)-1:0]  push_row_o,
  output tvmp_ctl_t                     push_ctl_o
);

  localparam int VA = $clog2(VECTOR_DEPTH);
  localparam int RA = $clog2(ROW_DEPTH);

  logic [VALUE_WIDTH-1:0] vec_mem [VECTOR_DEPTH];
  logic [VALUE_WIDTH-1:0] vec_rd_q;

  logic [VA-1:0]         load_ptr_q, load_ptr_d;
  logic [VA-1:0]         mid_q, mid_d;
  logic [RA-1:0]         right_q, right_d;
  logic [LEFT_CNT_W-1:0] left_q, left_d;
  logic [POS_WIDTH-1:0]  pos_q, pos_d;

  logic                   s1_valid_q;
  logic [VALUE_WIDTH-1:0] s1_value_q;
  logic [RA-1:0]          s1_row_q;
  tvmp_ctl_t              s1_ctl_q;

  logic accept, ld_wrap, r_last, m_last, l_last;

  assign in_stall_o = (32'(q_count_i) + 32'(s1_valid_q)) >= 32'(QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  assign ld_wrap = (32'(load_ptr_q) + 32'd1) >= 32'(cfg_i.vector_length);
  assign m_last  = (32'(mid_q) + 32'd1) >= 32'(cfg_i.vector_length);
  assign r_last  = (32'(right_q) + 32'd1) >= 32'(cfg_i.right_count);
  assign l_last  = (32'(left_q) + 32'd1) >= 32'(cfg_i.left_count);

  always_comb begin
    load_ptr_d = load_ptr_q;
    mid_d      = mid_q;
    right_d    = right_q;
    left_d     = left_q;
    pos_d      = pos_q;
    if (cfg_clear_i) begin
      load_ptr_d = '0;
      mid_d      = '0;
      right_d    = '0;
      left_d     = '0;
      pos_d      = '0;
    end else if (accept && !action_i) begin
      load_ptr_d = ld_wrap ? '0 : load_ptr_q + VA'(1);
    end else if (accept) begin
      if (m_last) begin
        pos_d = (l_last && r_last) ? '0 : pos_q + POS_WIDTH'(1);
      end
      if (r_last) begin
        right_d = '0;
        if (m_last) begin
          mid_d  = '0;
          left_d = l_last ? '0 : left_q + LEFT_CNT_W'(1);
        end else begin
          mid_d = mid_q + VA'(1);
        end
      end else begin
        right_d = right_q + RA'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_ptr_q <= '0;
      mid_q      <= '0;
      right_q    <= '0;
      left_q     <= '0;
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      load_ptr_q <= load_ptr_d;
      mid_q      <= mid_d;
      right_q    <= right_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
      s1_valid_q <= accept && action_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !action_i) begin
      vec_mem[load_ptr_q] <= value_i[VALUE_WIDTH-1:0];
    end
    if (accept && action_i) begin
      vec_rd_q       <= vec_mem[mid_q];
      s1_value_q     <= value_i[VALUE_WIDTH-1:0];
      s1_row_q       <= right_q;
      s1_ctl_q.first <= (mid_q == '0);
      s1_ctl_q.emit  <= m_last;
      s1_ctl_q.last  <= m_last && l_last && r_last;
      s1_ctl_q.pos   <= pos_q;
    end
  end

  assign push_o       = s1_valid_q;
  assign push_value_o = s1_value_q;
  assign push_vec_o   = vec_rd_q;
  assign push_row_o   = s1_row_q;
  assign push_ctl_o   = s1_ctl_q;

`ifndef SYNTHESIS
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (32'(q_count_i) < 32'(QUEUE_DEPTH)))
    else $error("Request pushed into a full queue.");

  a_clear_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_clear_i |=> (load_ptr_q == '0 && mid_q == '0 && right_q == '0 &&
                     left_q == '0 && pos_q == '0))
    else $error("Register write did not restart the pass.");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(load_ptr_q) < 32'(cfg_i.vector_length)) &&
    (32'(mid_q) < 32'(cfg_i.vector_length)) &&
    (32'(right_q) < 32'(cfg_i.right_count)))
    else $error("Index counter outside the configured range.");
`endif

endmodule

### design/tvmp_back.sv
// Back part: multiplies each request, accumulates per row with saturation and emits results.
// Depends on tvmp_pkg; pops requests from tvmp_fifo.
`timescale 1ns / 1ps

module tvmp_back
  import tvmp_pkg::*;
#(
  parameter int ROW_DEPTH   = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  output logic                          pop_o,
  input  logic [VALUE_WIDTH-1:0]        head_value_i,
  input  logic [VALUE_WIDTH-1:0]        head_vec_i,
  input  logic [$clog2(ROW_DEPTH)-1:0]  head_row_i,
  input  tvmp_ctl_t                     head_ctl_i,
  output logic                          result_valid_o,
  input  logic                          result_stall_i,
  output logic signed [63:0]            result_value_o,
  output logic [POS_WIDTH-1:0]          result_position_o,
  output logic                          last_result_o
);

  localparam int RA = $clog2(ROW_DEPTH);

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (!(a[63] ^ b[63]) && (a[63] ^ s[63])) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  logic [63:0] acc_mem [ROW_DEPTH];

  logic signed [2*VALUE_WIDTH-1:0] mult;
  logic        b1_valid_q;
  logic [63:0] b1_prod_q;
  logic [63:0] b1_acc_q;
  logic [RA-1:0] b1_row_q;
  tvmp_ctl_t   b1_ctl_q;

  logic          fwd_valid_q;
  logic [RA-1:0] fwd_row_q;
  logic [63:0]   fwd_sum_q;

  logic        out_free, b1_adv, b1_take;
  logic [63:0] old_sum, new_sum;

  assign mult = $signed(head_value_i) * $signed(head_vec_i);

  assign out_free = !result_valid_o || !result_stall_i;
  assign b1_adv   = b1_valid_q && (!b1_ctl_q.emit || out_free);
  assign b1_take  = !b1_valid_q || b1_adv;
  assign pop_o    = head_valid_i && b1_take;

  assign old_sum = (fwd_valid_q && fwd_row_q == b1_row_q) ? fwd_sum_q : b1_acc_q;
  assign new_sum = b1_ctl_q.first ? b1_prod_q : sat_add(old_sum, b1_prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q     <= 1'b0;
      fwd_valid_q    <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      b1_valid_q <= pop_o || (b1_valid_q && !b1_adv);
      if (b1_adv) begin
        fwd_valid_q <= 1'b1;
      end
      if (b1_adv && b1_ctl_q.emit) begin
        result_valid_o <= 1'b1;
      end else if (!result_stall_i) begin
        result_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_prod_q <= 64'(mult);
      b1_acc_q  <= acc_mem[head_row_i];
      b1_row_q  <= head_row_i;
      b1_ctl_q  <= head_ctl_i;
    end
    if (b1_adv) begin
      acc_mem[b1_row_q] <= new_sum;
      fwd_row_q         <= b1_row_q;
      fwd_sum_q         <= new_sum;
    end
    if (b1_adv && b1_ctl_q.emit) begin
      result_value_o    <= new_sum;
      result_position_o <= b1_ctl_q.pos;
      last_result_o     <= b1_ctl_q.last;
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for tensor_vector_mode_product_top: loads vectors, streams tensors and
// checks every output element against a predictor of the block. Depends on tvmp_pkg and the RTL.
`timescale 1ns / 1ps

module testbench
  import tvmp_pkg::*;
();

  localparam bit ACT_LOAD   = 1'b0;
  localparam bit ACT_STREAM = 1'b1;
  localparam int VEC_DEPTH  = 1024;
  localparam int ROWS       = 4096;

  typedef struct {
    logic signed [63:0]   value;
    logic [POS_WIDTH-1:0] position;
    logic                 last;
  } row_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic signed [31:0]    value_i;
  logic                  result_valid_o;
  logic                  result_stall_i;
  logic signed [63:0]    result_value_o;
  logic [POS_WIDTH-1:0]  result_position_o;
  logic                  last_result_o;

  logic [31:0]  vec_mem[VEC_DEPTH];
  bit           vec_written[VEC_DEPTH];
  longint       row_acc[ROWS];
  int unsigned  load_ptr, left_idx, mid_idx, right_idx;
  int unsigned  left_cfg, vlen_cfg, right_cfg;
  row_result_t  pending_sums[$];
  int           errors;
  bit           in_gaps_on;
  bit           out_gaps_on;
  int           stall_hold_cycles;

  tensor_vector_mode_product_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .value_i          (value_i),
    .result_valid_o   (result_valid_o),
    .result_stall_i   (result_stall_i),
    .result_value_o   (result_value_o),
    .result_position_o(result_position_o),
    .last_result_o    (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned clamp_count(longint unsigned v, int unsigned hi);
    if (v == 0) begin
      return 1;
    end
    if (v > hi) begin
      return hi;
    end
    return int'(v);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        return 32'h8000_0000;
      end
      1: begin
        return 32'h7FFF_FFFF;
      end
      2: begin
        return 32'hFFFF_FFFF;
      end
      3: begin
        return {8'h00, 8'($urandom_range(0, 255)), 16'h0000};
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic set_register(tvmp_reg_e idx, logic [31:0] data);
    case (idx)
      REG_LEFT_COUNT: begin
        left_cfg = clamp_count(data & 32'h1_FFFF, 65536);
      end
      REG_VECTOR_LENGTH: begin
        vlen_cfg = clamp_count(data & 32'h7FF, VEC_DEPTH);
      end
      REG_RIGHT_COUNT: begin
        right_cfg = clamp_count(data & 32'h1FFF, ROWS);
      end
      default: begin
      end
    endcase
    load_ptr  = 0;
    left_idx  = 0;
    mid_idx   = 0;
    right_idx = 0;
  endtask

  task automatic accumulate_element(bit act, logic [31:0] val);
    longint      prod;
    row_result_t res;
    if (act == ACT_LOAD) begin
      vec_mem[load_ptr]     = val;
      vec_written[load_ptr] = 1'b1;
      load_ptr = (load_ptr + 1 >= vlen_cfg) ? 0 : load_ptr + 1;
      return;
    end
    prod = longint'($signed(val)) * longint'($signed(vec_mem[mid_idx]));
    row_acc[right_idx] = (mid_idx == 0) ? prod : sat_sum(row_acc[right_idx], prod);
    if (mid_idx + 1 >= vlen_cfg) begin
      res.value    = row_acc[right_idx];
      res.position = POS_WIDTH'(left_idx * right_cfg + right_idx);
      res.last     = (left_idx + 1 >= left_cfg) && (right_idx + 1 >= right_cfg);
      pending_sums.push_back(res);
    end
    if (right_idx + 1 >= right_cfg) begin
      right_idx = 0;
      if (mid_idx + 1 >= vlen_cfg) begin
        mid_idx  = 0;
        left_idx = (left_idx + 1 >= left_cfg) ? 0 : left_idx + 1;
      end else begin
        mid_idx = mid_idx + 1;
      end
    end else begin
      right_idx = right_idx + 1;
    end
  endtask

  task automatic send_request(bit act, logic [31:0] val);
    if (in_gaps_on) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    accumulate_element(act, val);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(tvmp_reg_e idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_register(idx, data);
  endtask

  task automatic check_register(tvmp_reg_e idx, logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WIDTH'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d expected %h actual %h", $time, idx, want, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [31:0] left, logic [31:0] vlen, logic [31:0] right);
    drain_results();
    write_register(REG_LEFT_COUNT, left);
    write_register(REG_VECTOR_LENGTH, vlen);
    write_register(REG_RIGHT_COUNT, right);
  endtask

  task automatic load_vector();
    int unsigned n;
    n = vlen_cfg;
    for (int unsigned i = 0; i < n; i++) begin
      send_request(ACT_LOAD, pick_value());
    end
  endtask

  task automatic test_reset_defaults();
    logic [31:0] streamed[6];
    streamed = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h0001_0000, 32'h5555_AAAA};
    send_request(ACT_LOAD, 32'h7FFF_FFFF);
    foreach (streamed[i]) begin
      send_request(ACT_STREAM, streamed[i]);
    end
    send_request(ACT_LOAD, 32'h8000_0000);
    send_request(ACT_STREAM, 32'h8000_0000);
    send_request(ACT_STREAM, 32'hAAAA_5555);
  endtask

  task automatic test_saturation();
    configure(1, 4, 1);
    repeat (4) send_request(ACT_LOAD, 32'h8000_0000);
    repeat (4) send_request(ACT_STREAM, 32'h8000_0000);
    repeat (4) send_request(ACT_LOAD, 32'h7FFF_FFFF);
    repeat (4) send_request(ACT_STREAM, 32'h8000_0000);
  endtask

  task automatic test_register_limits();
    configure(32'h0001_FFFF, 32'h0000_0000, 32'h0000_1FFF);
    check_register(REG_LEFT_COUNT, left_cfg);
    check_register(REG_VECTOR_LENGTH, vlen_cfg);
    check_register(REG_RIGHT_COUNT, right_cfg);
    load_vector();
    repeat (100) send_request(ACT_STREAM, pick_value());
    drain_results();
    write_register(REG_RIGHT_COUNT, 32'h0000_0000);
    check_register(REG_RIGHT_COUNT, right_cfg);
    repeat (100) send_request(ACT_STREAM, pick_value());
    configure(32'hFFFE_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    check_register(REG_LEFT_COUNT, left_cfg);
    check_register(REG_VECTOR_LENGTH, vlen_cfg);
    check_register(REG_RIGHT_COUNT, right_cfg);
  endtask

  task automatic test_backpressure();
    configure(1, 1, 3);
    load_vector();
    in_gaps_on        = 1'b0;
    stall_hold_cycles = 60;
    repeat (40) send_request(ACT_STREAM, pick_value());
    in_gaps_on = 1'b1;
  endtask

  task automatic test_random_passes();
    int          sent;
    int unsigned count;
    logic [31:0] left, vlen, right;
    sent = 0;
    while (sent < 2000) begin
      case ($urandom_range(0, 9))
        0: left = 32'h0;
        1: left = 32'hFFFE_0000 | $urandom_range(1, 3);
        default: left = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0: vlen = 32'h0;
        1: vlen = 32'hFFFF_F800 | $urandom_range(1, 8);
        default: vlen = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: right = 32'h0;
        1: right = 32'hFFFF_E000 | $urandom_range(1, 8);
        default: right = $urandom_range(1, 8);
      endcase
      configure(left, vlen, right);
      in_gaps_on  = !(sent >= 800 && sent < 1400);
      out_gaps_on = in_gaps_on;
      load_vector();
      sent  = sent + vlen_cfg;
      count = left_cfg * vlen_cfg * right_cfg * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) begin
        count = $urandom_range(1, count);
      end
      for (int unsigned i = 0; i < count; i++) begin
        if ($urandom_range(0, 19) == 0 || !vec_written[mid_idx]) begin
          send_request(ACT_LOAD, pick_value());
        end else begin
          send_request(ACT_STREAM, pick_value());
        end
        sent++;
      end
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  initial begin
    result_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_hold_cycles > 0) begin
        result_stall_i <= 1'b1;
        stall_hold_cycles--;
      end else begin
        result_stall_i <= out_gaps_on && ($urandom_range(0, 99) < 26);
      end
    end
  end

  initial begin
    row_result_t want;
    forever begin
      @(posedge clk_i);
      if (result_valid_o && !result_stall_i) begin
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %h position %0d",
                   $time, result_value_o, result_position_o);
          errors++;
        end else begin
          want = pending_sums.pop_front();
          if (result_value_o !== want.value) begin
            $display("%0t: result_value expected %h actual %h",
                     $time, want.value, result_value_o);
            errors++;
          end
          if (result_position_o !== want.position) begin
            $display("%0t: result_position expected %0d actual %0d",
                     $time, want.position, result_position_o);
            errors++;
          end
          if (last_result_o !== want.last) begin
            $display("%0t: last_result expected %b actual %b",
                     $time, want.last, last_result_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_valid_i        = 1'b0;
    action_i          = ACT_LOAD;
    value_i           = '0;
    errors            = 0;
    in_gaps_on        = 1'b1;
    out_gaps_on       = 1'b1;
    stall_hold_cycles = 0;
    load_ptr          = 0;
    left_idx          = 0;
    mid_idx           = 0;
    right_idx         = 0;
    left_cfg          = 1;
    vlen_cfg          = 1;
    right_cfg         = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_saturation();
    test_register_limits();
    test_backpressure();
    test_random_passes();
    drain_results();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
